>>> hw/rtl/cktab_pkg.sv
package cktab_pkg;

  localparam int OP_W = 3;
  localparam int ST_W = 2;

  localparam logic [OP_W-1:0] OP_ADD     = 3'd0;
  localparam logic [OP_W-1:0] OP_CONSUME = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE  = 3'd2;
  localparam logic [OP_W-1:0] OP_APPEND  = 3'd3;
  localparam logic [OP_W-1:0] OP_READ    = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd5;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
  localparam logic [ST_W-1:0] ST_BAD_INDEX = 2'd3;

  localparam int IN_KEY_W   = 8;
  localparam int IN_IDX_W   = 5;
  localparam int IN_LOAD_W  = 16;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_IDX_W  = 5;
  localparam int OUT_KEY_W  = 8;
  localparam int OUT_CNT_W  = 16;
  localparam int OUT_OCC_W  = 6;
  localparam int OUT_DATA_W = 40;

endpackage

>>> hw/rtl/counted_key_table.sv
// Channel | Direction | tdata (lowest bit up)                                  | tuser
// in_     | slave     | item_key, entry_index, load_count                      | operation
// out_    | master    | hit_index, hit_key, hit_count, entry_removed, occupancy | status
//
// One operation is worked at a time against a single memory with a registered read.
// Add and consume scan all live entries before their result.
// A removal then shifts later entries down, one entry a cycle.
// Read passes through a read state before its result; append, clear and unused codes go straight to it.
// Reset empties the table at once; a waiting result does not block the next transfer.
// A second result holds in its last cycle, with the input stalled, until the first is taken.
module counted_key_table #(
  parameter int CAPACITY   = 32,
  parameter int KEY_BITS   = 8,
  parameter int COUNT_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [cktab_pkg::IN_DATA_W-1:0]  in_tdata,  // item_key, entry_index, load_count
  input  logic [cktab_pkg::OP_W-1:0]       in_tuser,  // operation
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [cktab_pkg::OUT_DATA_W-1:0] out_tdata, // hit_index, hit_key, hit_count,
                                                      // entry_removed, occupancy
  output logic [cktab_pkg::ST_W-1:0]       out_tuser  // status
);
  import cktab_pkg::*;

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int EW   = KEY_BITS + COUNT_BITS;
  localparam int CMPW = (CW > IN_IDX_W) ? CW : IN_IDX_W;
  localparam int LW   = (COUNT_BITS > IN_LOAD_W) ? COUNT_BITS : IN_LOAD_W;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]            state_r, state_nxt;
  logic [OP_W-1:0]       op_r, op_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [AW-1:0]         idx_r, idx_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [CW-1:0]         ptr_r, ptr_nxt;
  logic                  rd_pend_r, rd_pend_nxt;
  logic [AW-1:0]         rd_addr_r, rd_addr_nxt;
  logic                  found_r, found_nxt;
  logic [AW-1:0]         fpos_r, fpos_nxt;
  logic [COUNT_BITS-1:0] fcnt_r, fcnt_nxt;
  logic [ST_W-1:0]       res_st_r, res_st_nxt;
  logic [AW-1:0]         res_idx_r, res_idx_nxt;
  logic [KEY_BITS-1:0]   res_key_r, res_key_nxt;
  logic [COUNT_BITS-1:0] res_cnt_r, res_cnt_nxt;
  logic                  res_rem_r, res_rem_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [ST_W-1:0]       out_st_r, out_st_nxt;

  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [EW-1:0]         wr_data;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [EW-1:0]         rd_data;
  logic [KEY_BITS-1:0]   rd_key;
  logic [COUNT_BITS-1:0] rd_cnt;

  logic                  accept;
  logic [OP_W-1:0]       in_op;
  logic [KEY_BITS-1:0]   in_key;
  logic [IN_IDX_W-1:0]   in_idx;
  logic [IN_LOAD_W-1:0]  in_load;
  logic [COUNT_BITS-1:0] load_sat;
  logic                  full;
  logic                  idx_bad;

  assign in_op   = in_tuser;
  assign in_key  = KEY_BITS'(in_tdata[IN_KEY_W-1:0]);
  assign in_idx  = in_tdata[IN_KEY_W +: IN_IDX_W];
  assign in_load = in_tdata[IN_KEY_W + IN_IDX_W +: IN_LOAD_W];
  assign load_sat = (LW'(in_load) > LW'(CMAX)) ? CMAX : COUNT_BITS'(in_load);

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign full      = (cnt_r == CW'(CAPACITY));
  assign idx_bad   = (CMPW'(in_idx) >= CMPW'(cnt_r));
  assign rd_key    = rd_data[EW-1:COUNT_BITS];
  assign rd_cnt    = rd_data[COUNT_BITS-1:0];

  cktab_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (EW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    ptr_nxt       = ptr_r;
    rd_pend_nxt   = 1'b0;
    rd_addr_nxt   = rd_addr_r;
    found_nxt     = found_r;
    fpos_nxt      = fpos_r;
    fcnt_nxt      = fcnt_r;
    res_st_nxt    = res_st_r;
    res_idx_nxt   = res_idx_r;
    res_key_nxt   = res_key_r;
    res_cnt_nxt   = res_cnt_r;
    res_rem_nxt   = res_rem_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_st_nxt    = out_st_r;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;
    rd_en         = 1'b0;
    rd_addr       = ptr_r[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt      = in_op;
          key_nxt     = in_key;
          idx_nxt     = AW'(in_idx);
          ptr_nxt     = '0;
          found_nxt   = 1'b0;
          res_st_nxt  = ST_OK;
          res_idx_nxt = '0;
          res_key_nxt = '0;
          res_cnt_nxt = '0;
          res_rem_nxt = 1'b0;
          state_nxt   = S_DONE;
          case (in_op)
            OP_ADD, OP_CONSUME: begin
              state_nxt = S_SCAN;
            end
            OP_REMOVE, OP_READ: begin
              if (idx_bad) begin
                res_st_nxt = ST_BAD_INDEX;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = AW'(in_idx);
                state_nxt = S_READ;
              end
            end
            OP_APPEND: begin
              res_key_nxt = in_key;
              if (full) begin
                res_st_nxt = ST_FULL;
              end else begin
                wr_en       = 1'b1;
                wr_addr     = cnt_r[AW-1:0];
                wr_data     = {in_key, load_sat};
                res_idx_nxt = cnt_r[AW-1:0];
                res_cnt_nxt = load_sat;
                cnt_nxt     = cnt_r + CW'(1);
              end
            end
            OP_CLEAR: begin
              res_rem_nxt = (cnt_r != '0);
              cnt_nxt     = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        if (rd_pend_r && (rd_key == key_r)) begin
          found_nxt = 1'b1;
          fpos_nxt  = rd_addr_r;
          fcnt_nxt  = rd_cnt;
        end
        if (ptr_r < cnt_r) begin
          rd_en       = 1'b1;
          rd_pend_nxt = 1'b1;
          rd_addr_nxt = ptr_r[AW-1:0];
          ptr_nxt     = ptr_r + CW'(1);
        end else if (!rd_pend_r) begin
          res_key_nxt = key_r;
          state_nxt   = S_DONE;
          if (op_r == OP_ADD) begin
            if (found_r) begin
              wr_en       = 1'b1;
              wr_addr     = fpos_r;
              wr_data     = {key_r, (fcnt_r == CMAX) ? CMAX : fcnt_r + COUNT_BITS'(1)};
              res_idx_nxt = fpos_r;
              res_cnt_nxt = (fcnt_r == CMAX) ? CMAX : fcnt_r + COUNT_BITS'(1);
            end else if (full) begin
              res_st_nxt = ST_FULL;
            end else begin
              wr_en       = 1'b1;
              wr_addr     = cnt_r[AW-1:0];
              wr_data     = {key_r, COUNT_BITS'(1)};
              res_idx_nxt = cnt_r[AW-1:0];
              res_cnt_nxt = COUNT_BITS'(1);
              cnt_nxt     = cnt_r + CW'(1);
            end
          end else begin
            if (!found_r) begin
              res_st_nxt = ST_NOT_FOUND;
            end else if (fcnt_r <= COUNT_BITS'(1)) begin
              res_idx_nxt = fpos_r;
              res_rem_nxt = 1'b1;
              ptr_nxt     = CW'(fpos_r) + CW'(1);
              state_nxt   = S_SHIFT;
            end else begin
              wr_en       = 1'b1;
              wr_addr     = fpos_r;
              wr_data     = {key_r, fcnt_r - COUNT_BITS'(1)};
              res_idx_nxt = fpos_r;
              res_cnt_nxt = fcnt_r - COUNT_BITS'(1);
            end
          end
        end
      end

      S_READ: begin
        res_idx_nxt = idx_r;
        res_key_nxt = rd_key;
        res_cnt_nxt = rd_cnt;
        if (op_r == OP_REMOVE) begin
          res_rem_nxt = 1'b1;
          ptr_nxt     = CW'(idx_r) + CW'(1);
          state_nxt   = S_SHIFT;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_SHIFT: begin
        if (rd_pend_r) begin
          wr_en   = 1'b1;
          wr_addr = rd_addr_r - AW'(1);
          wr_data = rd_data;
        end
        if (ptr_r < cnt_r) begin
          rd_en       = 1'b1;
          rd_pend_nxt = 1'b1;
          rd_addr_nxt = ptr_r[AW-1:0];
          ptr_nxt     = ptr_r + CW'(1);
        end else if (!rd_pend_r) begin
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = res_st_r;
          out_data_nxt  = {{(OUT_DATA_W - OUT_OCC_W - 1 - OUT_CNT_W - OUT_KEY_W
                             - OUT_IDX_W){1'b0}},
                           OUT_OCC_W'(cnt_r), res_rem_r, OUT_CNT_W'(res_cnt_r),
                           OUT_KEY_W'(res_key_r), OUT_IDX_W'(res_idx_r)};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    idx_r      <= idx_nxt;
    ptr_r      <= ptr_nxt;
    rd_addr_r  <= rd_addr_nxt;
    found_r    <= found_nxt;
    fpos_r     <= fpos_nxt;
    fcnt_r     <= fcnt_nxt;
    res_st_r   <= res_st_nxt;
    res_idx_r  <= res_idx_nxt;
    res_key_r  <= res_key_nxt;
    res_cnt_r  <= res_cnt_nxt;
    res_rem_r  <= res_rem_nxt;
    out_data_r <= out_data_nxt;
    out_st_r   <= out_st_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_st_r;

endmodule

>>> hw/rtl/cktab_ram.sv
module cktab_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 24
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> tb/counted_key_table_test.sv
`timescale 1ns / 100ps

module counted_key_table_test;
  import cktab_pkg::*;

  localparam int CAPACITY = 32;
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;
  localparam logic [OUT_CNT_W-1:0] COUNT_TOP = '1;
  localparam int NUM_ROWS = 23;
  localparam int NUM_PHASES = 4;
  localparam int SEGMENTS = 9;
  localparam int SEGMENT_LEN = 48;
  localparam int HOLD_LEN = 400;
  localparam int STALL_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 200;

  typedef struct packed {
    logic [ST_W-1:0]      status;
    logic [OUT_IDX_W-1:0] hit_index;
    logic [OUT_KEY_W-1:0] hit_key;
    logic [OUT_CNT_W-1:0] hit_count;
    logic                 entry_removed;
    logic [OUT_OCC_W-1:0] occupancy;
  } table_result_t;

  typedef struct {
    logic [OP_W-1:0]      op;
    logic [IN_KEY_W-1:0]  key;
    logic [IN_IDX_W-1:0]  idx;
    logic [IN_LOAD_W-1:0] load;
    bit                   fixed;
    table_result_t        want;
  } probe_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [OP_W-1:0]       in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [ST_W-1:0]       out_tuser;

  logic [IN_KEY_W-1:0]  shadow_keys [CAPACITY];
  logic [OUT_CNT_W-1:0] shadow_counts [CAPACITY];
  int                   shadow_fill = 0;

  table_result_t pending_results [$];
  int error_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int holds_asked = 0;
  int holds_served = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  int op_weight [3][7] = '{'{35, 35, 5, 3, 20, 0, 2},
                           '{10, 5, 40, 25, 15, 3, 2},
                           '{25, 15, 25, 10, 20, 3, 2}};
  logic [OP_W-1:0] kind_op [7] = '{OP_ADD, OP_APPEND, OP_CONSUME, OP_REMOVE,
                                   OP_READ, OP_CLEAR, OP_SPARE_A};

  probe_row_t script [NUM_ROWS] = '{
    '{OP_READ,    8'h00, 5'd0,  16'h0000, 1'b1, '{ST_BAD_INDEX, 5'd0, 8'h00, 16'h0, 1'b0, 6'd0}},
    '{OP_CONSUME, 8'h00, 5'd0,  16'h0000, 1'b1, '{ST_NOT_FOUND, 5'd0, 8'h00, 16'h0, 1'b0, 6'd0}},
    '{OP_ADD,     8'hFF, 5'd0,  16'h0000, 1'b1, '{ST_OK, 5'd0, 8'hFF, 16'h1, 1'b0, 6'd1}},
    '{OP_REMOVE,  8'h00, 5'd31, 16'h0000, 1'b1, '{ST_BAD_INDEX, 5'd0, 8'h00, 16'h0, 1'b0, 6'd1}},
    '{OP_APPEND,  8'h00, 5'd0,  16'hFFFF, 1'b0, '0},
    '{OP_ADD,     8'h00, 5'd0,  16'h0000, 1'b0, '0},
    '{OP_APPEND,  8'hFF, 5'd0,  16'h0000, 1'b0, '0},
    '{OP_CONSUME, 8'hFF, 5'd0,  16'h0000, 1'b0, '0},
    '{OP_ADD,     8'hFF, 5'd0,  16'h0000, 1'b0, '0},
    '{OP_CONSUME, 8'hFF, 5'd0,  16'h0000, 1'b0, '0},
    '{OP_READ,    8'h00, 5'd1,  16'h0000, 1'b0, '0},
    '{OP_CONSUME, 8'h00, 5'd0,  16'h0000, 1'b0, '0},
    '{OP_APPEND,  8'h5A, 5'd0,  16'h0001, 1'b0, '0},
    '{OP_REMOVE,  8'h00, 5'd0,  16'h0000, 1'b0, '0},
    '{OP_READ,    8'h00, 5'd1,  16'h0000, 1'b0, '0},
    '{OP_CONSUME, 8'h5A, 5'd0,  16'h0000, 1'b0, '0},
    '{OP_READ,    8'h00, 5'd1,  16'h0000, 1'b0, '0},
    '{OP_SPARE_A, 8'hFF, 5'd31, 16'hFFFF, 1'b1, '{ST_OK, 5'd0, 8'h00, 16'h0, 1'b0, 6'd1}},
    '{OP_SPARE_B, 8'h00, 5'd0,  16'h0000, 1'b1, '{ST_OK, 5'd0, 8'h00, 16'h0, 1'b0, 6'd1}},
    '{OP_CLEAR,   8'h00, 5'd0,  16'h0000, 1'b1, '{ST_OK, 5'd0, 8'h00, 16'h0, 1'b1, 6'd0}},
    '{OP_CLEAR,   8'h00, 5'd0,  16'h0000, 1'b1, '{ST_OK, 5'd0, 8'h00, 16'h0, 1'b0, 6'd0}},
    '{OP_APPEND,  8'hA5, 5'd0,  16'h8001, 1'b0, '0},
    '{OP_REMOVE,  8'h00, 5'd0,  16'h0000, 1'b0, '0}
  };

  counted_key_table uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #5 clk = ~clk;

  function automatic int find_last(input logic [IN_KEY_W-1:0] key);
    int pos;
    pos = -1;
    for (int i = 0; i < shadow_fill; i++) begin
      if (shadow_keys[i] == key) pos = i;
    end
    return pos;
  endfunction

  function automatic void close_gap(input int pos);
    for (int i = pos; i + 1 < shadow_fill; i++) begin
      shadow_keys[i] = shadow_keys[i + 1];
      shadow_counts[i] = shadow_counts[i + 1];
    end
    shadow_fill--;
  endfunction

  function automatic table_result_t apply_op(input logic [OP_W-1:0] op,
                                             input logic [IN_KEY_W-1:0] key,
                                             input logic [IN_IDX_W-1:0] idx,
                                             input logic [IN_LOAD_W-1:0] load);
    table_result_t r;
    int pos;
    r = '0;
    case (op)
      OP_ADD: begin
        pos = find_last(key);
        r.hit_key = key;
        if (pos >= 0) begin
          if (shadow_counts[pos] != COUNT_TOP) shadow_counts[pos]++;
          r.hit_index = OUT_IDX_W'(pos);
          r.hit_count = shadow_counts[pos];
        end else if (shadow_fill >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          shadow_keys[shadow_fill] = key;
          shadow_counts[shadow_fill] = OUT_CNT_W'(1);
          r.hit_index = OUT_IDX_W'(shadow_fill);
          r.hit_count = OUT_CNT_W'(1);
          shadow_fill++;
        end
      end
      OP_CONSUME: begin
        pos = find_last(key);
        r.hit_key = key;
        if (pos < 0) begin
          r.status = ST_NOT_FOUND;
        end else if (shadow_counts[pos] <= OUT_CNT_W'(1)) begin
          r.hit_index = OUT_IDX_W'(pos);
          r.entry_removed = 1'b1;
          close_gap(pos);
        end else begin
          shadow_counts[pos]--;
          r.hit_index = OUT_IDX_W'(pos);
          r.hit_count = shadow_counts[pos];
        end
      end
      OP_REMOVE, OP_READ: begin
        if (int'(idx) >= shadow_fill) begin
          r.status = ST_BAD_INDEX;
        end else begin
          r.hit_index = idx;
          r.hit_key = shadow_keys[idx];
          r.hit_count = shadow_counts[idx];
          if (op == OP_REMOVE) begin
            r.entry_removed = 1'b1;
            close_gap(int'(idx));
          end
        end
      end
      OP_APPEND: begin
        r.hit_key = key;
        if (shadow_fill >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          shadow_keys[shadow_fill] = key;
          shadow_counts[shadow_fill] = load;
          r.hit_index = OUT_IDX_W'(shadow_fill);
          r.hit_count = load;
          shadow_fill++;
        end
      end
      OP_CLEAR: begin
        r.entry_removed = (shadow_fill > 0);
        shadow_fill = 0;
      end
      default: begin
      end
    endcase
    r.occupancy = OUT_OCC_W'(shadow_fill);
    return r;
  endfunction

  function automatic string show_result(input table_result_t r);
    return $sformatf("status %0d index %0d key %02h count %04h removed %0d occupancy %0d",
                     r.status, r.hit_index, r.hit_key, r.hit_count, r.entry_removed,
                     r.occupancy);
  endfunction

  function automatic void flag_error(input string what);
    error_count++;
    if (error_count <= 10) $display("ERROR at %0t: %s", $realtime, what);
  endfunction

  task automatic send_op(input logic [OP_W-1:0] op, input logic [IN_KEY_W-1:0] key,
                         input logic [IN_IDX_W-1:0] idx, input logic [IN_LOAD_W-1:0] load,
                         input bit fixed, input table_result_t want);
    table_result_t forecast;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {3'b000, load, idx, key};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    forecast = apply_op(op, key, idx, load);
    pending_results.push_back(fixed ? want : forecast);
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (holds_served != holds_asked) begin
      holds_served = holds_asked;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    table_result_t got;
    table_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = out_tuser;
      got.hit_index = out_tdata[4:0];
      got.hit_key = out_tdata[12:5];
      got.hit_count = out_tdata[28:13];
      got.entry_removed = out_tdata[29];
      got.occupancy = out_tdata[35:30];
      if (pending_results.size() == 0) begin
        flag_error({"unexpected result: ", show_result(got)});
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          flag_error({"expected ", show_result(want), ", got ", show_result(got)});
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    int mode;
    int pick;
    int acc;
    int kind;
    logic [OP_W-1:0] op;
    logic [IN_KEY_W-1:0] key;
    logic [IN_IDX_W-1:0] idx;
    logic [IN_LOAD_W-1:0] load;
    logic [IN_KEY_W-1:0] key_pool [6];
    int idle_plan [NUM_PHASES] = '{0, 59, 0, 6};
    int stall_plan [NUM_PHASES] = '{0, 0, 59, 6};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    foreach (script[r]) begin
      send_op(script[r].op, script[r].key, script[r].idx, script[r].load,
              script[r].fixed, script[r].want);
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      wait_for_results();
      send_idle_pct = idle_plan[phase];
      stall_pct = stall_plan[phase];
      for (int seg = 0; seg < SEGMENTS; seg++) begin
        // A long receiver hold-off lets the table back up into the input.
        if (seg == 3 && (phase == 0 || phase == 3)) holds_asked++;
        if (seg == 6) wait_for_results();
        mode = $urandom_range(3);
        if (mode == 3) mode = 0;
        foreach (key_pool[j]) key_pool[j] = IN_KEY_W'($urandom_range(255));
        for (int n = 0; n < SEGMENT_LEN; n++) begin
          pick = $urandom_range(99);
          acc = 0;
          kind = 6;
          for (int k = 0; k < 7; k++) begin
            acc += op_weight[mode][k];
            if (pick < acc) begin
              kind = k;
              break;
            end
          end
          op = kind_op[kind];
          if (op == OP_SPARE_A && $urandom_range(1) == 1) op = OP_SPARE_B;
          if ($urandom_range(4) == 0) begin
            key = IN_KEY_W'($urandom_range(255));
          end else begin
            key = key_pool[$urandom_range(5)];
          end
          if ($urandom_range(3) == 0) begin
            idx = IN_IDX_W'($urandom_range(31));
          end else begin
            idx = IN_IDX_W'($urandom_range(shadow_fill > 31 ? 31 : shadow_fill));
          end
          case ($urandom_range(9))
            0: load = '0;
            1: load = '1;
            2: load = IN_LOAD_W'($urandom_range(3, 1));
            default: load = IN_LOAD_W'($urandom_range(16'hFFFF));
          endcase
          send_op(op, key, idx, load, 1'b0, '0);
        end
      end
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
